[rtl/core/audio_capture_ring_window_reader_top_defines.svh]
// assertion macros for the audio capture ring window reader
// used by the port checker, depends on nothing else
`ifndef AUDIO_CAPTURE_RING_WINDOW_READER_TOP_DEFINES_SVH
`define AUDIO_CAPTURE_RING_WINDOW_READER_TOP_DEFINES_SVH

// same-cycle implication
`define ACRW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acrw port assertion failed");

// next-cycle implication
`define ACRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acrw port assertion failed");

`endif

[rtl/core/acrw_pkg.sv]
// shared types, constants and helpers of the audio capture ring window reader
// no dependencies
package acrw_pkg;

  localparam int RING_DEPTH     = 32768;
  localparam int SAMPLES_PER_MS = 16;
  localparam int MAX_WINDOW     = 512;
  localparam int QUEUE_DEPTH    = 2;

  localparam int START_W  = 28;
  localparam int DUR_W    = 10;
  localparam int POS_W    = 9;
  localparam int SMP_W    = 16;
  localparam int WSAMP_W  = 14;
  localparam int TS_W     = 28;
  localparam int GAIN_W   = 5;

  localparam logic [GAIN_W-1:0]        GAIN_RESET = 5'd4;
  localparam logic signed [SMP_W-1:0]  SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0]  SAMPLE_MIN = 16'sh8000;
  localparam logic [WSAMP_W-1:0]       WSAMP_MAX  = 14'h3FFF;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOD,
    BK_RD,
    BK_WAIT
  } bk_state_e;

  typedef struct packed {
    logic                      cmd;
    logic signed [SMP_W-1:0]   mic_sample;
    logic [START_W-1:0]        win_start;
    logic [DUR_W-1:0]          win_len;
    logic [POS_W-1:0]          window_position;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]   sample_out;
    logic [WSAMP_W-1:0]        window_samples;
    logic                      window_error;
    logic [TS_W-1:0]           timestamp_ms;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SMP_W-1:0]   sample;
    logic [WSAMP_W-1:0]        wsamp;
    logic                      werr;
    logic                      in_win;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // width of the absolute sample index start * spm + pos
  function automatic int idx_width(input int spm);
    return START_W + $clog2(spm) + 1;
  endfunction

endpackage

[rtl/core/acrw_chan_if.sv]
// valid/ready channel carrying one payload per transaction
// depends on nothing, payload type set per instance
interface acrw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/acrw_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module acrw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/acrw_fifo.sv]
// short queue between the front and back parts
// no dependencies
module acrw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/acrw_front.sv]
// front part: gain register, command accept and classification
// depends on acrw_pkg and acrw_chan_if
module acrw_front #(
  parameter int SAMPLES_PER_MS = acrw_pkg::SAMPLES_PER_MS,
  parameter int MAX_WINDOW     = acrw_pkg::MAX_WINDOW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  acrw_chan_if.sink            cmd_i,
  acrw_chan_if.sink            cfg_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output acrw_pkg::item_t      q_item_o,
  output logic [acrw_pkg::idx_width(SAMPLES_PER_MS)-1:0] q_idx_o
);

  localparam int IDX_W  = acrw_pkg::idx_width(SAMPLES_PER_MS);
  localparam int WL_W   = acrw_pkg::DUR_W + $clog2(SAMPLES_PER_MS) + 1;
  localparam int PROD_W = acrw_pkg::SMP_W + acrw_pkg::GAIN_W + 1;
  localparam int WS_W   = acrw_pkg::WSAMP_W;

  logic [acrw_pkg::GAIN_W-1:0]       gain_q;
  logic signed [PROD_W-1:0]          prod;
  logic signed [acrw_pkg::SMP_W-1:0] sat;
  logic [WL_W-1:0]                   wlen;
  logic                              werr;
  acrw_pkg::cmd_e                    cmd;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = !q_full_i;
  assign q_push_o    = cmd_i.valid && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= acrw_pkg::GAIN_RESET;
    end else if (cfg_i.valid) begin
      gain_q <= cfg_i.data;
    end
  end

  always_comb begin
    cmd  = acrw_pkg::cmd_e'(cmd_i.data.cmd);
    prod = PROD_W'(cmd_i.data.mic_sample) * PROD_W'($signed({1'b0, gain_q}));
    if (prod > PROD_W'(acrw_pkg::SAMPLE_MAX)) begin
      sat = acrw_pkg::SAMPLE_MAX;
    end else if (prod < PROD_W'(acrw_pkg::SAMPLE_MIN)) begin
      sat = acrw_pkg::SAMPLE_MIN;
    end else begin
      sat = prod[acrw_pkg::SMP_W-1:0];
    end

    wlen = WL_W'(cmd_i.data.win_len) * WL_W'(SAMPLES_PER_MS);
    werr = 32'(wlen) > 32'(MAX_WINDOW);

    q_idx_o = IDX_W'(cmd_i.data.win_start) * IDX_W'(SAMPLES_PER_MS)
            + IDX_W'(cmd_i.data.window_position);

    q_item_o.cmd = cmd;
    if (cmd == acrw_pkg::CMD_CAPTURE) begin
      q_item_o.sample = sat;
      q_item_o.wsamp  = '0;
      q_item_o.werr   = 1'b0;
      q_item_o.in_win = 1'b0;
    end else begin
      q_item_o.sample = '0;
      q_item_o.wsamp  = (32'(wlen) > 32'(acrw_pkg::WSAMP_MAX)) ? acrw_pkg::WSAMP_MAX
                                                               : WS_W'(wlen);
      q_item_o.werr   = werr;
      q_item_o.in_win = !werr && (32'(cmd_i.data.window_position) < 32'(wlen));
    end
  end

endmodule

[rtl/core/acrw_back.sv]
// back part: ring writes, index reduction, ring reads, counters and result register
// depends on acrw_pkg and acrw_chan_if, drives the external acrw_ram
module acrw_back #(
  parameter int RING_DEPTH     = acrw_pkg::RING_DEPTH,
  parameter int SAMPLES_PER_MS = acrw_pkg::SAMPLES_PER_MS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  acrw_pkg::item_t                   q_item_i,
  input  logic [acrw_pkg::idx_width(SAMPLES_PER_MS)-1:0] q_idx_i,
  output logic                              q_pop_o,
  output logic                              ram_we_o,
  output logic [$clog2(RING_DEPTH)-1:0]     ram_waddr_o,
  output logic [acrw_pkg::SMP_W-1:0]        ram_wdata_o,
  output logic                              ram_re_o,
  output logic [$clog2(RING_DEPTH)-1:0]     ram_raddr_o,
  input  logic [acrw_pkg::SMP_W-1:0]        ram_rdata_i,
  acrw_chan_if.source                       res_o
);

  localparam int  IDX_W   = acrw_pkg::idx_width(SAMPLES_PER_MS);
  localparam int  AW      = $clog2(RING_DEPTH);
  localparam int  BW      = $clog2(IDX_W);
  localparam int  SW      = (SAMPLES_PER_MS > 1) ? $clog2(SAMPLES_PER_MS) : 1;
  localparam int  CMP_W   = (IDX_W > 32) ? IDX_W : 32;
  localparam bit  IS_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;

  acrw_pkg::bk_state_e state_q, state_d;

  logic [31:0]              count_q, count_d;
  logic [AW-1:0]            wr_ptr_q, wr_ptr_d;
  logic                     full_q, full_d;
  logic [SW-1:0]            sub_q, sub_d;
  logic [acrw_pkg::TS_W-1:0] ms_q, ms_d;

  acrw_pkg::item_t          rd_item_q;
  logic [IDX_W-1:0]         idx_q;
  logic [AW-1:0]            rem_q, rem_d;
  logic [AW:0]              rem_t;
  logic [BW-1:0]            bit_q;
  logic                     hit_q, hit_d;

  logic                     out_valid_q;
  acrw_pkg::out_item_t      out_data_q;

  logic                     slot_free;
  logic                     pop, cap_go, rd_go, out_load_rd;
  logic [CMP_W-1:0]         cnt_ext, oldest;
  logic                     written;

  assign slot_free = !out_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      acrw_pkg::BK_IDLE: begin
        if (q_valid_i && q_item_i.cmd == acrw_pkg::CMD_READ) begin
          state_d = IS_POW2 ? acrw_pkg::BK_RD : acrw_pkg::BK_MOD;
        end
      end
      acrw_pkg::BK_MOD: begin
        if (bit_q == '0) begin
          state_d = acrw_pkg::BK_RD;
        end
      end
      acrw_pkg::BK_RD: begin
        state_d = acrw_pkg::BK_WAIT;
      end
      acrw_pkg::BK_WAIT: begin
        if (slot_free) begin
          state_d = acrw_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = acrw_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop         = 1'b0;
    ram_re_o    = 1'b0;
    out_load_rd = 1'b0;
    case (state_q)
      acrw_pkg::BK_IDLE: begin
        pop = q_valid_i && (q_item_i.cmd == acrw_pkg::CMD_READ || slot_free);
      end
      acrw_pkg::BK_RD: begin
        ram_re_o = 1'b1;
      end
      acrw_pkg::BK_WAIT: begin
        out_load_rd = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    cap_go = pop && q_item_i.cmd == acrw_pkg::CMD_CAPTURE;
    rd_go  = pop && q_item_i.cmd == acrw_pkg::CMD_READ;
  end

  assign q_pop_o     = pop;
  assign ram_we_o    = cap_go;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = q_item_i.sample;
  assign ram_raddr_o = IS_POW2 ? idx_q[AW-1:0] : rem_q;

  // capture counters
  always_comb begin
    count_d  = count_q;
    wr_ptr_d = wr_ptr_q;
    full_d   = full_q;
    sub_d    = sub_q;
    ms_d     = ms_q;
    if (cap_go) begin
      count_d  = count_q + 32'd1;
      wr_ptr_d = (wr_ptr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      full_d   = full_q || (wr_ptr_q == AW'(RING_DEPTH - 1));
      if (count_q == 32'hFFFF_FFFF) begin
        sub_d = '0;
        ms_d  = '0;
      end else if (sub_q == SW'(SAMPLES_PER_MS - 1)) begin
        sub_d = '0;
        ms_d  = ms_q + 1'b1;
      end else begin
        sub_d = sub_q + 1'b1;
      end
    end
  end

  // index reduction and hit check
  always_comb begin
    rem_t = {rem_q, idx_q[bit_q]};
    if (rem_t >= (AW + 1)'(RING_DEPTH)) begin
      rem_d = AW'(rem_t - (AW + 1)'(RING_DEPTH));
    end else begin
      rem_d = rem_t[AW-1:0];
    end
    cnt_ext = CMP_W'(count_q);
    oldest  = (cnt_ext > CMP_W'(RING_DEPTH)) ? cnt_ext - CMP_W'(RING_DEPTH) : '0;
    written = full_q || (ram_raddr_o < wr_ptr_q);
    hit_d   = rd_item_q.in_win && (CMP_W'(idx_q) >= oldest) && written;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acrw_pkg::BK_IDLE;
      count_q     <= '0;
      wr_ptr_q    <= '0;
      full_q      <= 1'b0;
      sub_q       <= '0;
      ms_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_d;
      full_q   <= full_d;
      sub_q    <= sub_d;
      ms_q     <= ms_d;
      if (cap_go || out_load_rd) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      rd_item_q <= q_item_i;
      idx_q     <= q_idx_i;
      rem_q     <= '0;
      bit_q     <= BW'(IDX_W - 1);
    end else if (state_q == acrw_pkg::BK_MOD) begin
      rem_q <= rem_d;
      bit_q <= bit_q - 1'b1;
    end
    if (state_q == acrw_pkg::BK_RD) begin
      hit_q <= hit_d;
    end
    if (cap_go) begin
      out_data_q.sample_out     <= q_item_i.sample;
      out_data_q.window_samples <= q_item_i.wsamp;
      out_data_q.window_error   <= q_item_i.werr;
      out_data_q.timestamp_ms   <= ms_d;
    end else if (out_load_rd) begin
      out_data_q.sample_out     <= hit_q ? $signed(ram_rdata_i) : '0;
      out_data_q.window_samples <= rd_item_q.wsamp;
      out_data_q.window_error   <= rd_item_q.werr;
      out_data_q.timestamp_ms   <= ms_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

endmodule

[rtl/core/audio_capture_ring_window_reader_top.sv]
// top level of the audio capture ring window reader
// depends on acrw_pkg, acrw_chan_if, acrw_ram, acrw_fifo, acrw_front, acrw_back
//
//   channel  | dir | payload               | handshake
//   ---------+-----+-----------------------+-------------------------
//   cmd_i    | in  | acrw_pkg::in_item_t   | valid/ready, transaction
//   res_o    | out | acrw_pkg::out_item_t  | valid/ready, transaction
//   cfg_i    | in  | mic_gain, 5 bits      | valid/ready, ready held high
//
// a capture is written to the ring and the result register directly; a read holds
// the back part through BK_RD (ring read via the registered ram port) and BK_WAIT,
// after serial index reduction in BK_MOD when RING_DEPTH is not a power of two.
// reset clears counters and queues at once; the ring has no clearing pass, a fill
// count marks entries never written so they read as zero.
// a stalled result holds in the output register while the queue keeps filling.
module audio_capture_ring_window_reader_top #(
  parameter int RING_DEPTH     = acrw_pkg::RING_DEPTH,
  parameter int SAMPLES_PER_MS = acrw_pkg::SAMPLES_PER_MS,
  parameter int MAX_WINDOW     = acrw_pkg::MAX_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acrw_chan_if.sink   cmd_i,
  acrw_chan_if.source res_o,
  acrw_chan_if.sink   cfg_i
);

  localparam int IDX_W = acrw_pkg::idx_width(SAMPLES_PER_MS);
  localparam int AW    = $clog2(RING_DEPTH);
  localparam int QW    = acrw_pkg::ITEM_W + IDX_W;

  logic                       q_full, q_empty, q_push, q_pop;
  acrw_pkg::item_t            f_item, b_item;
  logic [IDX_W-1:0]           f_idx, b_idx;
  logic [QW-1:0]              q_rdata;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [acrw_pkg::SMP_W-1:0] ram_wdata, ram_rdata;

  acrw_front #(
    .SAMPLES_PER_MS (SAMPLES_PER_MS),
    .MAX_WINDOW     (MAX_WINDOW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (f_item),
    .q_idx_o  (f_idx)
  );

  acrw_fifo #(
    .WIDTH (QW),
    .DEPTH (acrw_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_idx, f_item}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_item = acrw_pkg::item_t'(q_rdata[acrw_pkg::ITEM_W-1:0]);
  assign b_idx  = q_rdata[QW-1:acrw_pkg::ITEM_W];

  acrw_back #(
    .RING_DEPTH     (RING_DEPTH),
    .SAMPLES_PER_MS (SAMPLES_PER_MS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_item_i    (b_item),
    .q_idx_i     (b_idx),
    .q_pop_o     (q_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res_o)
  );

  acrw_ram #(
    .WIDTH (acrw_pkg::SMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[rtl/core/acrw_checker.sv]
// port checker for the audio capture ring window reader, bound to the top level
// depends on acrw_pkg and the assertion macro header
`include "audio_capture_ring_window_reader_top_defines.svh"

module acrw_checker #(
  parameter int MAX_WINDOW = acrw_pkg::MAX_WINDOW
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input acrw_pkg::out_item_t out_data_i
);

  `ACRW_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ACRW_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))
  `ACRW_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_i && out_data_i.window_error, out_data_i.sample_out == '0)
  `ACRW_ASSERT_IMPL(a_err_len, clk_i, rst_ni, out_valid_i, out_data_i.window_error == (32'(out_data_i.window_samples) > 32'(MAX_WINDOW)))

endmodule

bind audio_capture_ring_window_reader_top acrw_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_acrw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
